@@ hw/rtl/i2crm_pkg.sv @@
`default_nettype none
package i2crm_pkg;

  localparam int TICKS_PER_PHASE = 1;
  localparam int TIMER_W = 8;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd72;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  reg_pointer;
    logic [15:0] write_value;
    logic        sda_in;
  } cmd_t;

  typedef struct packed {
    logic        scl_low;
    logic        sda_low;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
    logic        nack_error;
    logic        sticky_error;
  } res_t;

endpackage
`default_nettype wire

@@ hw/rtl/i2crm_front.sv @@
`default_nettype none
module i2crm_front import i2crm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  reg_pointer,
  input  wire logic [15:0] write_value,
  input  wire logic        sda_in,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  wire logic        cmd_pop
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       decoded;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    decoded.reg_pointer = reg_pointer;
    decoded.write_value = write_value;
    decoded.sda_in      = sda_in;
    case (req_type)
      REQ_TICK:  decoded.kind = KIND_TICK;
      REQ_WRITE: decoded.kind = KIND_WRITE;
      REQ_READ:  decoded.kind = KIND_READ;
      default:   decoded.kind = KIND_NONE;
    endcase
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/i2crm_seq.sv @@
`default_nettype none
module i2crm_seq import i2crm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [6:0] cfg_data,
  input  wire logic       cmd_valid,
  input  wire cmd_t       cmd,
  output logic            cmd_pop,
  input  wire logic       res_full,
  output logic            res_valid,
  output res_t            res
);

  typedef enum logic [15:0] {
    ST_IDLE    = 16'h0001,
    ST_START_A = 16'h0002,
    ST_START_B = 16'h0004,
    ST_BIT_LO  = 16'h0008,
    ST_BIT_HI  = 16'h0010,
    ST_ACK_LO  = 16'h0020,
    ST_ACK_HI  = 16'h0040,
    ST_RS_A    = 16'h0080,
    ST_RS_B    = 16'h0100,
    ST_RS_C    = 16'h0200,
    ST_RD_LO   = 16'h0400,
    ST_RD_HI   = 16'h0800,
    ST_MA_LO   = 16'h1000,
    ST_MA_HI   = 16'h2000,
    ST_STOP_A  = 16'h4000,
    ST_STOP_B  = 16'h8000
  } state_t;

  state_t              state, state_next;
  logic [6:0]          device_address;
  logic [3:0]          bit_counter, bit_counter_next;
  logic [7:0]          shift_byte, shift_byte_next;
  logic [2:0]          byte_index, byte_index_next;
  logic                read_mode, read_mode_next;
  logic [7:0]          pointer_hold, pointer_hold_next;
  logic [15:0]         value_hold, value_hold_next;
  logic [15:0]         data_collect, data_collect_next;
  logic                error_seen, error_seen_next;
  logic                aborted, aborted_next;
  logic [TIMER_W-1:0]  phase_timer, phase_timer_next;
  logic [TIMER_W:0]    timer_inc;
  logic [3:0]          bc_inc;
  logic [2:0]          bi_inc;
  logic                busy;
  logic                done;
  logic                take;
  logic [1:0]          drive;

  function automatic logic [7:0] byte_for(input logic [2:0] idx, input logic rd,
                                          input logic [6:0] addr, input logic [7:0] ptr,
                                          input logic [15:0] val);
    logic [7:0] a;
    a = {addr, 1'b0};
    if (idx == 3'd0) return a;
    if (idx == 3'd1) return ptr & BYTE_MASK;
    if (rd) return {addr, 1'b1};
    if (idx == 3'd2) return val[15:8];
    return val[7:0];
  endfunction

  // bit0: SCL low, bit1: SDA low
  function automatic logic [1:0] drive_for(input state_t st, input logic msb,
                                           input logic [2:0] bi);
    logic [1:0] d;
    case (st)
      ST_START_A: d = 2'b10;
      ST_START_B: d = 2'b11;
      ST_BIT_LO:  d = {~msb, 1'b1};
      ST_BIT_HI:  d = {~msb, 1'b0};
      ST_ACK_LO:  d = 2'b01;
      ST_ACK_HI:  d = 2'b00;
      ST_RS_A:    d = 2'b01;
      ST_RS_B:    d = 2'b00;
      ST_RS_C:    d = 2'b10;
      ST_RD_LO:   d = 2'b01;
      ST_RD_HI:   d = 2'b00;
      ST_MA_LO:   d = {(bi == 3'd3), 1'b1};
      ST_MA_HI:   d = {(bi == 3'd3), 1'b0};
      ST_STOP_A:  d = 2'b11;
      ST_STOP_B:  d = 2'b10;
      default:    d = 2'b00;
    endcase
    return d;
  endfunction

  assign busy      = (state != ST_IDLE);
  assign take      = cmd_valid && !res_full;
  assign cmd_pop   = take;
  assign res_valid = take;
  assign timer_inc = {1'b0, phase_timer} + {{TIMER_W{1'b0}}, 1'b1};
  assign bc_inc    = bit_counter + 4'd1;
  assign bi_inc    = byte_index + 3'd1;

  always_comb begin
    state_next        = state;
    bit_counter_next  = bit_counter;
    shift_byte_next   = shift_byte;
    byte_index_next   = byte_index;
    read_mode_next    = read_mode;
    pointer_hold_next = pointer_hold;
    value_hold_next   = value_hold;
    data_collect_next = data_collect;
    error_seen_next   = error_seen;
    aborted_next      = aborted;
    phase_timer_next  = phase_timer;
    done              = 1'b0;

    case (cmd.kind)
      KIND_WRITE, KIND_READ: begin
        if (!busy) begin
          read_mode_next    = (cmd.kind == KIND_READ);
          pointer_hold_next = cmd.reg_pointer;
          value_hold_next   = cmd.write_value;
          data_collect_next = 16'd0;
          aborted_next      = 1'b0;
          byte_index_next   = 3'd0;
          shift_byte_next   = {device_address, 1'b0};
          bit_counter_next  = 4'd0;
          phase_timer_next  = '0;
          state_next        = ST_START_A;
        end
      end
      KIND_TICK: begin
        if (busy) begin
          if (timer_inc >= (TIMER_W+1)'(TICKS_PER_PHASE)) begin
            phase_timer_next = '0;
            case (state)
              ST_START_A: state_next = ST_START_B;
              ST_START_B: begin
                bit_counter_next = 4'd0;
                state_next       = ST_BIT_LO;
              end
              ST_BIT_LO: state_next = ST_BIT_HI;
              ST_BIT_HI: begin
                bit_counter_next = bc_inc;
                if (bc_inc >= 4'd8) begin
                  state_next = ST_ACK_LO;
                end else begin
                  shift_byte_next = {shift_byte[6:0], 1'b0};
                  state_next      = ST_BIT_LO;
                end
              end
              ST_ACK_LO: state_next = ST_ACK_HI;
              ST_ACK_HI: begin
                // SDA high in the acknowledge slot: NACK, abort with a stop
                if (cmd.sda_in) begin
                  error_seen_next   = 1'b1;
                  aborted_next      = 1'b1;
                  data_collect_next = 16'd0;
                  state_next        = ST_STOP_A;
                end else begin
                  byte_index_next = bi_inc;
                  if (!read_mode) begin
                    if (bi_inc >= 3'd4) begin
                      state_next = ST_STOP_A;
                    end else begin
                      shift_byte_next  = byte_for(bi_inc, read_mode, device_address,
                                                  pointer_hold, value_hold);
                      bit_counter_next = 4'd0;
                      state_next       = ST_BIT_LO;
                    end
                  end else if (bi_inc == 3'd1) begin
                    shift_byte_next  = byte_for(3'd1, read_mode, device_address,
                                                pointer_hold, value_hold);
                    bit_counter_next = 4'd0;
                    state_next       = ST_BIT_LO;
                  end else if (bi_inc == 3'd2) begin
                    shift_byte_next  = byte_for(3'd2, read_mode, device_address,
                                                pointer_hold, value_hold);
                    bit_counter_next = 4'd0;
                    state_next       = ST_RS_A;
                  end else begin
                    byte_index_next  = 3'd3;
                    bit_counter_next = 4'd0;
                    state_next       = ST_RD_LO;
                  end
                end
              end
              ST_RS_A:  state_next = ST_RS_B;
              ST_RS_B:  state_next = ST_RS_C;
              ST_RS_C:  state_next = ST_START_B;
              ST_RD_LO: state_next = ST_RD_HI;
              ST_RD_HI: begin
                data_collect_next = {data_collect[14:0], cmd.sda_in};
                bit_counter_next  = bc_inc;
                state_next        = (bc_inc >= 4'd8) ? ST_MA_LO : ST_RD_LO;
              end
              ST_MA_LO: state_next = ST_MA_HI;
              ST_MA_HI: begin
                if (byte_index == 3'd3) begin
                  byte_index_next  = 3'd4;
                  bit_counter_next = 4'd0;
                  state_next       = ST_RD_LO;
                end else begin
                  state_next = ST_STOP_A;
                end
              end
              ST_STOP_A: state_next = ST_STOP_B;
              ST_STOP_B: begin
                state_next = ST_IDLE;
                done       = 1'b1;
              end
              default: state_next = ST_IDLE;
            endcase
          end else begin
            phase_timer_next = timer_inc[TIMER_W-1:0];
          end
        end
      end
      default: ;
    endcase

    drive = drive_for(state_next, shift_byte_next[7], byte_index_next);
    res.scl_low      = drive[0];
    res.sda_low      = drive[1];
    res.busy_res     = (state_next != ST_IDLE);
    res.done_res     = done;
    res.read_data    = done ? data_collect_next : 16'd0;
    res.nack_error   = done && aborted_next;
    res.sticky_error = error_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RESET;
    end else if (cfg_write) begin
      device_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      bit_counter  <= 4'd0;
      shift_byte   <= 8'd0;
      byte_index   <= 3'd0;
      read_mode    <= 1'b0;
      pointer_hold <= 8'd0;
      value_hold   <= 16'd0;
      data_collect <= 16'd0;
      error_seen   <= 1'b0;
      aborted      <= 1'b0;
      phase_timer  <= '0;
    end else if (take) begin
      state        <= state_next;
      bit_counter  <= bit_counter_next;
      shift_byte   <= shift_byte_next;
      byte_index   <= byte_index_next;
      read_mode    <= read_mode_next;
      pointer_hold <= pointer_hold_next;
      value_hold   <= value_hold_next;
      data_collect <= data_collect_next;
      error_seen   <= error_seen_next;
      aborted      <= aborted_next;
      phase_timer  <= phase_timer_next;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.done_res |-> !res.busy_res)
    else $error("done reported while still busy");

  a_nack_sticky: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.nack_error |-> res.done_res && res.sticky_error)
    else $error("nack without done or sticky error");

  a_data_on_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.read_data != 16'd0) |-> res.done_res)
    else $error("read data outside a done transaction");

  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.busy_res |-> !res.scl_low && !res.sda_low)
    else $error("lines driven while idle");

  a_sticky_holds: assert property (@(posedge clk) disable iff (rst)
    error_seen |=> error_seen)
    else $error("sticky error cleared");

endmodule
`default_nettype wire

@@ hw/rtl/i2crm_outq.sv @@
`default_nettype none
module i2crm_outq import i2crm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic res_valid,
  input  wire res_t res,
  output logic      res_full,
  output logic      empty,
  input  wire logic pop,
  output res_t      head
);

  res_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign head     = slots[rd_ptr];
  assign do_push  = res_valid && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/i2c_register_master_top.sv @@
// A pushed transaction is registered in the input queue, then its result in the
// output queue, before it shows (empty low). Throughput: one item per cycle while
// the output queue has room; one sequencer step per item, taken by the phase
// sequencer between two 2-entry queues. Reset (rst, synchronous, active high):
// queues empty, sequencer idle, sticky error cleared, device address back to 72.
`default_nettype none
module i2c_register_master_top import i2crm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  reg_pointer,
  input  wire logic [15:0] write_value,
  input  wire logic        sda_in,
  input  wire logic        cfg_write,
  input  wire logic [6:0]  cfg_data,
  output logic             empty,
  input  wire logic        pop,
  output logic             scl_low,
  output logic             sda_low,
  output logic             busy_res,
  output logic             done_res,
  output logic [15:0]      read_data,
  output logic             nack_error,
  output logic             sticky_error
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic res_valid;
  res_t res;
  logic res_full;
  res_t head;

  i2crm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .reg_pointer (reg_pointer),
    .write_value (write_value),
    .sda_in      (sda_in),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  i2crm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_valid (res_valid),
    .res       (res)
  );

  i2crm_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_full  (res_full),
    .empty     (empty),
    .pop       (pop),
    .head      (head)
  );

  assign scl_low      = head.scl_low;
  assign sda_low      = head.sda_low;
  assign busy_res     = head.busy_res;
  assign done_res     = head.done_res;
  assign read_data    = head.read_data;
  assign nack_error   = head.nack_error;
  assign sticky_error = head.sticky_error;

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none
module testbench;
  import i2crm_pkg::*;

  // Line phases of the bus sequencer, as the predictor tracks them.
  typedef enum logic [5:0] {
    ST_IDLE    = 6'd0,
    ST_START_A = 6'd1,
    ST_START_B = 6'd2,
    ST_BIT_LO  = 6'd3,
    ST_BIT_HI  = 6'd4,
    ST_ACK_LO  = 6'd5,
    ST_ACK_HI  = 6'd6,
    ST_RS_A    = 6'd7,
    ST_RS_B    = 6'd8,
    ST_RS_C    = 6'd9,
    ST_RD_LO   = 6'd10,
    ST_RD_HI   = 6'd11,
    ST_MA_LO   = 6'd12,
    ST_MA_HI   = 6'd13,
    ST_STOP_A  = 6'd14,
    ST_STOP_B  = 6'd15
  } bus_step_t;

  class master_scoreboard;
    logic [6:0]  dev_addr;
    bus_step_t   step;
    logic [3:0]  bit_cnt;
    logic [7:0]  shift;
    logic [2:0]  byte_idx;
    logic        read_mode;
    logic [7:0]  ptr;
    logic [15:0] val;
    logic [15:0] collect;
    logic        err;
    logic        aborted;
    logic [7:0]  timer;
    res_t        pending_results[$];
    int          mismatches;
    int          results_seen;

    function new();
      dev_addr = DEVICE_ADDRESS_RESET;
      step = ST_IDLE;
      bit_cnt = '0;
      shift = '0;
      byte_idx = '0;
      read_mode = 1'b0;
      ptr = '0;
      val = '0;
      collect = '0;
      err = 1'b0;
      aborted = 1'b0;
      timer = '0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function bit busy();
      return step != ST_IDLE;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void set_address(logic [6:0] a);
      dev_addr = a;
    endfunction

    // Address is taken live at each load.
    function logic [7:0] byte_for(logic [2:0] idx);
      logic [7:0] addr;
      addr = {dev_addr, 1'b0};
      if (idx == 3'd0) return addr;
      if (idx == 3'd1) return ptr;
      if (read_mode) return addr | 8'h01;
      if (idx == 3'd2) return val[15:8];
      return val[7:0];
    endfunction

    function void load_byte(logic [2:0] idx);
      shift = byte_for(idx);
      bit_cnt = '0;
    endfunction

    // {sda_low, scl_low} driven in the current phase
    function logic [1:0] lines_for();
      logic last_byte;
      last_byte = (byte_idx == 3'd3);
      case (step)
        ST_START_A: return 2'b10;
        ST_START_B: return 2'b11;
        ST_BIT_LO:  return {~shift[7], 1'b1};
        ST_BIT_HI:  return {~shift[7], 1'b0};
        ST_ACK_LO:  return 2'b01;
        ST_ACK_HI:  return 2'b00;
        ST_RS_A:    return 2'b01;
        ST_RS_B:    return 2'b00;
        ST_RS_C:    return 2'b10;
        ST_RD_LO:   return 2'b01;
        ST_RD_HI:   return 2'b00;
        ST_MA_LO:   return {last_byte, 1'b1};
        ST_MA_HI:   return {last_byte, 1'b0};
        ST_STOP_A:  return 2'b11;
        ST_STOP_B:  return 2'b10;
        default:    return 2'b00;
      endcase
    endfunction

    function bit advance(logic s);
      bit fin;
      fin = 1'b0;
      case (step)
        ST_START_A: step = ST_START_B;
        ST_START_B: begin
          bit_cnt = '0;
          step = ST_BIT_LO;
        end
        ST_BIT_LO: step = ST_BIT_HI;
        ST_BIT_HI: begin
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            step = ST_ACK_LO;
          end else begin
            shift = shift << 1;
            step = ST_BIT_LO;
          end
        end
        ST_ACK_LO: step = ST_ACK_HI;
        ST_ACK_HI: begin
          if (s) begin
            // target NACK: abort through a stop
            err = 1'b1;
            aborted = 1'b1;
            collect = '0;
            step = ST_STOP_A;
          end else begin
            byte_idx = byte_idx + 3'd1;
            if (!read_mode) begin
              if (byte_idx >= 3'd4) begin
                step = ST_STOP_A;
              end else begin
                load_byte(byte_idx);
                step = ST_BIT_LO;
              end
            end else if (byte_idx == 3'd1) begin
              load_byte(3'd1);
              step = ST_BIT_LO;
            end else if (byte_idx == 3'd2) begin
              load_byte(3'd2);
              step = ST_RS_A;
            end else begin
              byte_idx = 3'd3;
              bit_cnt = '0;
              step = ST_RD_LO;
            end
          end
        end
        ST_RS_A: step = ST_RS_B;
        ST_RS_B: step = ST_RS_C;
        ST_RS_C: step = ST_START_B;
        ST_RD_LO: step = ST_RD_HI;
        ST_RD_HI: begin
          collect = {collect[14:0], s};
          bit_cnt = bit_cnt + 4'd1;
          step = (bit_cnt >= 4'd8) ? ST_MA_LO : ST_RD_LO;
        end
        ST_MA_LO: step = ST_MA_HI;
        ST_MA_HI: begin
          if (byte_idx == 3'd3) begin
            byte_idx = 3'd4;
            bit_cnt = '0;
            step = ST_RD_LO;
          end else begin
            step = ST_STOP_A;
          end
        end
        ST_STOP_A: step = ST_STOP_B;
        ST_STOP_B: begin
          step = ST_IDLE;
          fin = 1'b1;
        end
        default: step = ST_IDLE;
      endcase
      return fin;
    endfunction

    function void note_request(cmd_t c);
      bit was_busy;
      bit fin;
      int t;
      logic [1:0] lines;
      res_t want;
      was_busy = busy();
      fin = 1'b0;
      if ((c.kind == KIND_WRITE || c.kind == KIND_READ) && !was_busy) begin
        read_mode = (c.kind == KIND_READ);
        ptr = c.reg_pointer;
        val = c.write_value;
        collect = '0;
        aborted = 1'b0;
        byte_idx = '0;
        load_byte(3'd0);
        timer = '0;
        step = ST_START_A;
      end else if (c.kind == KIND_TICK && was_busy) begin
        t = int'(timer) + 1;
        if (t >= TICKS_PER_PHASE) begin
          timer = '0;
          fin = advance(c.sda_in);
        end else begin
          timer = t[7:0];
        end
      end
      lines = lines_for();
      want.scl_low = lines[0];
      want.sda_low = lines[1];
      want.busy_res = busy();
      want.done_res = fin;
      want.read_data = fin ? collect : 16'h0000;
      want.nack_error = fin && aborted;
      want.sticky_error = err;
      pending_results.push_back(want);
    endfunction

    task report(string msg);
      $display("MISMATCH result %0d: %s", results_seen, msg);
      mismatches++;
    endtask

    task cmp(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        cmp("scl_low", 16'(got.scl_low), 16'(want.scl_low));
        cmp("sda_low", 16'(got.sda_low), 16'(want.sda_low));
        cmp("busy_res", 16'(got.busy_res), 16'(want.busy_res));
        cmp("done_res", 16'(got.done_res), 16'(want.done_res));
        cmp("read_data", got.read_data, want.read_data);
        cmp("nack_error", 16'(got.nack_error), 16'(want.nack_error));
        cmp("sticky_error", 16'(got.sticky_error), 16'(want.sticky_error));
      end
      results_seen++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  req_type = REQ_TICK;
  logic [7:0]  reg_pointer = '0;
  logic [15:0] write_value = '0;
  logic        sda_in = 1'b0;
  logic        cfg_write = 1'b0;
  logic [6:0]  cfg_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        scl_low;
  logic        sda_low;
  logic        busy_res;
  logic        done_res;
  logic [15:0] read_data;
  logic        nack_error;
  logic        sticky_error;

  master_scoreboard sb;
  bit quiet = 1'b0;
  int pop_hold = 0;

  always #4 clk = ~clk;

  i2c_register_master_top uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .req_type(req_type),
    .reg_pointer(reg_pointer),
    .write_value(write_value),
    .sda_in(sda_in),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .empty(empty),
    .pop(pop),
    .scl_low(scl_low),
    .sda_low(sda_low),
    .busy_res(busy_res),
    .done_res(done_res),
    .read_data(read_data),
    .nack_error(nack_error),
    .sticky_error(sticky_error)
  );

  always @(posedge clk) begin : watch
    cmd_t cmd;
    res_t got;
    if (!rst) begin
      if (cfg_write) sb.set_address(cfg_data);
      if (push && !full) begin
        cmd.kind = kind_t'(req_type);
        cmd.reg_pointer = reg_pointer;
        cmd.write_value = write_value;
        cmd.sda_in = sda_in;
        sb.note_request(cmd);
      end
      if (pop && !empty) begin
        got.scl_low = scl_low;
        got.sda_low = sda_low;
        got.busy_res = busy_res;
        got.done_res = done_res;
        got.read_data = read_data;
        got.nack_error = nack_error;
        got.sticky_error = sticky_error;
        sb.check_result(got);
      end
    end
  end

  // result side: random stalls, plus one long hold requested by the sender
  initial begin
    forever begin
      @(negedge clk);
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else if (quiet || $urandom_range(99) >= 16) begin
        pop <= 1'b1;
      end else begin
        pop <= 1'b0;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input kind_t k, input logic [7:0] p, input logic [15:0] v,
                           input logic s);
    while (!quiet && $urandom_range(99) < 16) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    req_type <= k;
    reg_pointer <= p;
    write_value <= v;
    sda_in <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly well-formed transactions: ACK slots see a NACK only now and then.
  task automatic send_random(output bit counted);
    kind_t k;
    logic s;
    int r;
    r = $urandom_range(99);
    if (!sb.busy()) begin
      if (r < 28) k = KIND_WRITE;
      else if (r < 55) k = KIND_READ;
      else if (r < 70) k = KIND_NONE;
      else k = KIND_TICK;
      counted = (k == KIND_WRITE || k == KIND_READ);
    end else begin
      if (r < 92) k = KIND_TICK;
      else if (r < 96) k = ($urandom_range(1) != 0) ? KIND_WRITE : KIND_READ;
      else k = KIND_NONE;
      counted = (k == KIND_TICK);
    end
    if (sb.busy() && sb.step == ST_ACK_HI) s = ($urandom_range(99) < 6);
    else s = 1'($urandom_range(1));
    send_item(k, 8'($urandom_range(255)), 16'($urandom_range(65535)), s);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (sb.pending() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int n;
    bit counted;
    logic [6:0] addr;
    sb = new();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: idle tick, unused selector, write at field maxima, request while
    // busy, then a NACK on the address byte that aborts through a stop
    send_item(KIND_TICK, 8'h00, 16'h0000, 1'b1);
    send_item(KIND_NONE, 8'hFF, 16'hFFFF, 1'b1);
    send_item(KIND_WRITE, 8'hFF, 16'hFFFF, 1'b1);
    send_item(KIND_READ, 8'h00, 16'h0000, 1'b0);
    do send_item(KIND_TICK, 8'h00, 16'h0000, 1'b1); while (sb.busy());
    push <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 0) addr = 7'd0;
      else if (ph == 1) addr = 7'd127;
      else addr = 7'($urandom_range(127));
      cfg_write <= 1'b1;
      cfg_data <= addr;
      @(negedge clk);
      cfg_write <= 1'b0;
      if (ph == 1) pop_hold = 80;
      quiet = (ph == 2);
      n = 0;
      while (n < 250) begin
        send_random(counted);
        if (counted) n++;
      end
      push <= 1'b0;
      quiet = 1'b0;
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
